// ===== src/kdd_pkg.sv =====
package kdd_pkg;

   localparam int unsigned KEY_COUNT = 12;
   localparam int unsigned ROW_WIDTH = 4;
   localparam int unsigned CHAR_WIDTH = 6;
   localparam int unsigned INDEX_WIDTH = 4;
   localparam int unsigned COUNT_WIDTH = 8;

   localparam logic [COUNT_WIDTH-1:0] THRESHOLD_RESET = 8'd5;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 8'd255;

   typedef logic [KEY_COUNT-1:0] image_type;

   typedef struct packed {
      logic                   hit;
      logic [CHAR_WIDTH-1:0]  key_char;
      logic [INDEX_WIDTH-1:0] key_index;
   } key_result_type;

   // Low six bits of the ASCII code for each image bit position.
   function automatic logic [CHAR_WIDTH-1:0] key_char_of(input logic [INDEX_WIDTH-1:0] idx);
      logic [7:0] ascii;
      unique case (idx)
         4'd0:    ascii = 8'h33;
         4'd1:    ascii = 8'h36;
         4'd2:    ascii = 8'h39;
         4'd3:    ascii = 8'h23;
         4'd4:    ascii = 8'h32;
         4'd5:    ascii = 8'h35;
         4'd6:    ascii = 8'h38;
         4'd7:    ascii = 8'h30;
         4'd8:    ascii = 8'h31;
         4'd9:    ascii = 8'h34;
         4'd10:   ascii = 8'h37;
         4'd11:   ascii = 8'h2A;
         default: ascii = 8'h00;
      endcase
      return ascii[CHAR_WIDTH-1:0];
   endfunction

endpackage

// ===== src/kdd_key_decode.sv =====
module kdd_key_decode
   import kdd_pkg::*;
(
   input  image_type      image,
   output key_result_type result
);

   logic                   single;
   logic [INDEX_WIDTH-1:0] idx;

   assign single = (image != '0) && ((image & (image - image_type'(1))) == '0);

   always_comb begin
      idx = '0;
      for (int unsigned k = 0; k < KEY_COUNT; k++) begin
         if (image[k]) begin
            idx = idx | INDEX_WIDTH'(k);
         end
      end
   end

   assign result.hit       = single;
   assign result.key_index = idx;
   assign result.key_char  = key_char_of(idx);

endmodule

// ===== src/keypad_debounce_decoder_top.sv =====
// Debounced decoder for a 3x4 matrix keypad.
// Each beat on the req_ channel is one scan tick: the row readings taken
// while each of the three columns was driven, packed into a 12-bit image.
// An image that differs from the stable image counts up a change counter,
// which saturates at 255; a matching image clears it. Once the count
// exceeds the debounce threshold, the image becomes the new stable image,
// and if exactly one key is down a beat with the low six bits of its ASCII
// code and its bit index leaves on the rsp_ channel. Other ticks give no beat.
// The threshold is written through csr_wr_en and csr_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
// A beat taken sits in the input register and is processed from there into
// the output register, which drives rsp_. Throughput is one beat per cycle,
// set by the single input and output register pair, while rsp_ is not stalled.
// When the receiver stalls, the output register holds its beat; the input
// register still takes one more beat, and ticks that give no result pass
// through without waiting. Reset clears the stable image, the counter and
// both valid flags and sets the threshold to 5.
module keypad_debounce_decoder_top
   import kdd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Bits 3:0 rows_first_column, 7:4 rows_second_column, 11:8 rows_third_column.
   input  logic [15:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Bits 5:0 key_char, 9:6 key_index.
   output logic [15:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   logic                   in_valid_ff;
   image_type              in_image_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [CHAR_WIDTH-1:0]  out_char_ff;
   logic [INDEX_WIDTH-1:0] out_index_ff;
   image_type              stable_image_ff, stable_image_in;
   logic [COUNT_WIDTH-1:0] change_count_ff, change_count_in;
   logic [COUNT_WIDTH-1:0] threshold_ff;

   logic           differs;
   logic           take_image;
   logic           emit;
   logic           process;
   logic           out_free;
   key_result_type decoded;

   kdd_key_decode u_decode (
      .image  (in_image_ff),
      .result (decoded)
   );

   assign differs  = in_image_ff != stable_image_ff;
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      change_count_in = '0;
      if (differs) begin
         change_count_in = (change_count_ff == COUNT_MAX) ? COUNT_MAX
                                                          : change_count_ff + 8'd1;
      end
   end

   assign take_image      = differs && (change_count_in > threshold_ff);
   assign stable_image_in = take_image ? in_image_ff : stable_image_ff;
   assign emit            = take_image && decoded.hit;
   assign process         = in_valid_ff && (out_free || !emit);
   assign req_tready      = !in_valid_ff || process;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      if (process && emit) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         stable_image_ff <= '0;
         change_count_ff <= '0;
         threshold_ff    <= THRESHOLD_RESET;
      end else begin
         out_valid_ff <= out_valid_in;
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (process) begin
            stable_image_ff <= stable_image_in;
            change_count_ff <= change_count_in;
         end
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_image_ff <= req_tdata[KEY_COUNT-1:0];
      end
      if (process && emit) begin
         out_char_ff  <= decoded.key_char;
         out_index_ff <= decoded.key_index;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'b0, out_index_ff, out_char_ff};

`ifndef SYNTHESIS
   a_emit_onehot: assert property (@(posedge clock) disable iff (reset)
      process && emit |=> $onehot(stable_image_ff))
      else $error("emitted key but stable image is not a single key");

   a_match_clears: assert property (@(posedge clock) disable iff (reset)
      process && !differs |=> change_count_ff == '0)
      else $error("change counter not cleared on matching image");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> out_index_ff < INDEX_WIDTH'(KEY_COUNT))
      else $error("key index out of range");

   a_max_threshold: assert property (@(posedge clock) disable iff (reset)
      threshold_ff == COUNT_MAX |-> !take_image)
      else $error("image taken with maximum threshold");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_tready |-> !(process && emit))
      else $error("pending result overwritten");
`endif

endmodule
